/* src/m4mul_pkg.sv */
package m4mul_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEMS     = DIM * DIM;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W    = $clog2(ELEMS);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);
  localparam int OUT_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_RUN
  } seq_state_e;

  // One read issued to both stores, with the position it belongs to.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } issue_t;

endpackage

/* src/m4mul_in_if.sv */
interface m4mul_in_if import m4mul_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_value;
  logic signed [DATA_W-1:0] right_value;

  modport source (output valid, left_value, right_value, input ready);
  modport sink   (input valid, left_value, right_value, output ready);
endinterface

/* src/m4mul_out_if.sv */
interface m4mul_out_if import m4mul_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product_value;
  logic [OUT_IDX_W-1:0]     row_index;
  logic [OUT_IDX_W-1:0]     col_index;
  logic                     saturated;
  logic                     last;

  modport source (output valid, product_value, row_index, col_index, saturated, last,
                  input ready);
  modport sink   (input valid, product_value, row_index, col_index, saturated, last,
                  output ready);
endinterface

/* src/m4mul_ram.sv */
module m4mul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/m4mul_seq.sv */
module m4mul_seq import m4mul_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  m4mul_in_if.sink          in_i,
  input  logic              adv_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] left_raddr_o,
  output logic [ADDR_W-1:0] right_raddr_o,
  output issue_t            issue_o
);

  seq_state_e       state_q, state_d;
  logic [ADDR_W-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]  row_q, row_d, col_q, col_d, k_q, k_d;
  logic              accept;
  logic              k_end, col_end, row_end;

  assign accept  = in_i.valid && in_i.ready;
  assign k_end   = (k_q == IDX_W'(DIM - 1));
  assign col_end = (col_q == IDX_W'(DIM - 1));
  assign row_end = (row_q == IDX_W'(DIM - 1));

  assign we_o    = accept;
  assign waddr_o = load_cnt_q;

  assign left_raddr_o  = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(DIM) + ADDR_W'(k_q));
  assign right_raddr_o = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    in_i.ready = 1'b0;
    re_o       = 1'b0;

    issue_o.valid     = 1'b0;
    issue_o.first     = (k_q == '0);
    issue_o.last_k    = k_end;
    issue_o.last_elem = row_end && col_end;
    issue_o.row       = row_q;
    issue_o.col       = col_q;

    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (load_cnt_q == ADDR_W'(ELEMS - 1)) begin
            load_cnt_d = '0;
            state_d    = ST_RUN;
          end else begin
            load_cnt_d = load_cnt_q + ADDR_W'(1);
          end
        end
      end
      ST_RUN: begin
        issue_o.valid = 1'b1;
        re_o          = adv_i;
        // step k, then column, then row; return to loading after the last read
        if (adv_i) begin
          if (k_end) begin
            k_d = '0;
            if (col_end) begin
              col_d = '0;
              if (row_end) begin
                row_d   = '0;
                state_d = ST_LOAD;
              end else begin
                row_d = row_q + IDX_W'(1);
              end
            end else begin
              col_d = col_q + IDX_W'(1);
            end
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

/* src/m4mul_mac.sv */
module m4mul_mac import m4mul_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  issue_t                   issue_i,
  input  logic signed [DATA_W-1:0] left_data_i,
  input  logic signed [DATA_W-1:0] right_data_i,
  output logic                     adv_o,
  m4mul_out_if.source              out_o
);

  issue_t                   s1_q, s2_q, s3_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    high_bits;
  logic                     fits;
  logic                     done;

  logic                     out_vld_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic [OUT_IDX_W-1:0]     out_row_q, out_col_q;
  logic                     out_sat_q, out_last_q;

  // the whole pipe, store reads included, holds while a result waits
  assign adv_o = !out_vld_q || out_o.ready;
  assign done  = s3_q.valid && s3_q.last_k;

  assign shifted   = acc_q >>> FRAC_BITS;
  assign high_bits = shifted[ACC_W-1:DATA_W-1];
  assign fits      = (&high_bits) || !(|high_bits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      s3_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      s1_q      <= issue_i;
      s2_q      <= s1_q;
      s3_q      <= s2_q;
      out_vld_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      prod_q <= left_data_i * right_data_i;
      if (s2_q.valid) begin
        if (s2_q.first) begin
          acc_q <= ACC_W'(prod_q);
        end else begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
      end
      if (done) begin
        if (fits) begin
          out_val_q <= shifted[DATA_W-1:0];
        end else if (acc_q[ACC_W-1]) begin
          out_val_q <= VAL_MIN;
        end else begin
          out_val_q <= VAL_MAX;
        end
        out_sat_q  <= !fits;
        out_row_q  <= OUT_IDX_W'(s3_q.row);
        out_col_q  <= OUT_IDX_W'(s3_q.col);
        out_last_q <= s3_q.last_elem;
      end
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.product_value = out_val_q;
  assign out_o.row_index     = out_row_q;
  assign out_o.col_index     = out_col_q;
  assign out_o.saturated     = out_sat_q;
  assign out_o.last          = out_last_q;

endmodule

/* src/matrix4_multiply.sv */
// 4x4 matrix product in Q16.16. Send sixteen words, each carrying one element
// of the left and of the right matrix at the same row-major position; they are
// taken one per cycle into two store memories. After the sixteenth word the
// block runs 64 multiply-accumulate steps on one shared 32x32 multiplier, one
// step per cycle unless the output stalls, reading both stores on each step,
// and returns the sixteen product elements row-major, the last one marked
// with last. Each element is the exact sum of four 64-bit products, shifted
// right 16 (toward minus infinity) and clipped to 32 bits, with saturated set
// when clipped. The next load is accepted while the last results drain. A
// stalled output halts the whole multiply pipe. No clearing pass after reset.
module matrix4_multiply import m4mul_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  m4mul_in_if.sink    in_i,
  m4mul_out_if.source out_o
);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic              re;
  logic [ADDR_W-1:0] left_raddr, right_raddr;
  logic [DATA_W-1:0] left_rdata, right_rdata;
  logic              adv;
  issue_t            issue;

  m4mul_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .adv_i         (adv),
    .we_o          (we),
    .waddr_o       (waddr),
    .re_o          (re),
    .left_raddr_o  (left_raddr),
    .right_raddr_o (right_raddr),
    .issue_o       (issue)
  );

  m4mul_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ELEMS)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.left_value),
    .re_i    (re),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  m4mul_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ELEMS)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.right_value),
    .re_i    (re),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  m4mul_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .left_data_i  (left_rdata),
    .right_data_i (right_rdata),
    .adv_o        (adv),
    .out_o        (out_o)
  );

endmodule

/* tb/sv/matrix4_multiply_tb.sv */
module matrix4_multiply_tb import m4mul_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOADS      = 23;     // one directed load, the rest random
  localparam int HOLD_START = 40;     // product element at which the sink stalls
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 100;

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 sat;
    logic                 last;
  } element_t;

  class product_scoreboard;
    logic signed [DATA_W-1:0] left_mem [ELEMS];
    logic signed [DATA_W-1:0] right_mem [ELEMS];
    int unsigned              load_pos;
    element_t                 pending_elems [$];
    int unsigned              words_taken;
    int unsigned              loads_done;
    int unsigned              elems_checked;
    int unsigned              clipped_elems;
    int unsigned              mismatches;

    function new();
      load_pos      = 0;
      words_taken   = 0;
      loads_done    = 0;
      elems_checked = 0;
      clipped_elems = 0;
      mismatches    = 0;
    endfunction

    function void note_word(logic signed [DATA_W-1:0] lv, logic signed [DATA_W-1:0] rv);
      left_mem[load_pos]  = lv;
      right_mem[load_pos] = rv;
      words_taken++;
      if (load_pos == ELEMS - 1) begin
        load_pos = 0;
        loads_done++;
        multiply_stores();
      end else begin
        load_pos++;
      end
    endfunction

    // Exact dot products in 128 bits, arithmetic shift, clip to 32 bits.
    function void multiply_stores();
      logic signed [127:0]        acc;
      logic signed [127:0]        scaled;
      logic signed [127:0]        top_lim;
      logic signed [127:0]        bot_lim;
      logic signed [2*DATA_W-1:0] term;
      element_t                   e;
      top_lim = VAL_MAX;
      bot_lim = VAL_MIN;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            term = left_mem[r*DIM + k] * right_mem[k*DIM + c];
            acc  = acc + term;
          end
          scaled = acc >>> FRAC_BITS;
          e.sat  = 1'b1;
          if (scaled > top_lim) begin
            e.value = VAL_MAX;
          end else if (scaled < bot_lim) begin
            e.value = VAL_MIN;
          end else begin
            e.value = scaled[DATA_W-1:0];
            e.sat   = 1'b0;
          end
          e.row  = OUT_IDX_W'(r);
          e.col  = OUT_IDX_W'(c);
          e.last = (r*DIM + c == ELEMS - 1);
          pending_elems.push_back(e);
        end
      end
    endfunction

    function int pending();
      return pending_elems.size();
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] expv, logic [DATA_W-1:0] actv);
      if (expv !== actv) begin
        $error("%s: expected %h, got %h", name, expv, actv);
        mismatches++;
      end
    endfunction

    function void check_element(element_t got);
      element_t want;
      if (pending_elems.size() == 0) begin
        $error("product element %h (row %0d col %0d) with nothing pending",
               got.value, got.row, got.col);
        mismatches++;
        return;
      end
      want = pending_elems.pop_front();
      compare_field("product_value", want.value, got.value);
      compare_field("row_index", DATA_W'(want.row), DATA_W'(got.row));
      compare_field("col_index", DATA_W'(want.col), DATA_W'(got.col));
      compare_field("saturated", DATA_W'(want.sat), DATA_W'(got.sat));
      compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
      elems_checked++;
      if (want.sat) clipped_elems++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  m4mul_in_if  in_bus ();
  m4mul_out_if out_bus ();

  matrix4_multiply dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  product_scoreboard sb = new();
  int unsigned       idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mix of ranges: full-scale values mostly clip, small ones keep sums in range.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1:       v = int'($urandom);
      2, 3, 4, 5: v = int'($urandom_range(0, 524288)) - 262144;
      6, 7:       v = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      8: begin
        case ($urandom_range(0, 6))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = 0;
          3:       v = -1;
          4:       v = 1;
          5:       v = 65536;
          default: v = -65536;
        endcase
      end
      default:    v = int'($urandom) >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] directed_left(int pos);
    case (pos / DIM)
      0:       return VAL_MAX;
      1:       return -1;
      2:       return 0;
      default: return (pos % 2 == 0) ? VAL_MIN : 1;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] directed_right(int pos);
    case (pos % DIM)
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return 1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  task automatic send_word(logic signed [DATA_W-1:0] lv, logic signed [DATA_W-1:0] rv,
                           int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.left_value  <= lv;
    in_bus.right_value <= rv;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_word(lv, rv);
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin : sink_loop
      int       gap;
      int       seen;
      element_t got;
      seen = sb.elems_checked;
      if (seen == HOLD_START) gap = HOLD_LEN;
      else if (seen >= 12*ELEMS && seen < 14*ELEMS) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got.value = out_bus.product_value;
      got.row   = out_bus.row_index;
      got.col   = out_bus.col_index;
      got.sat   = out_bus.saturated;
      got.last  = out_bus.last;
      sb.check_element(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d elements pending",
                 idle_cycles, sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.left_value  <= '0;
    in_bus.right_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = 0; m < LOADS; m++) begin
      // let the block drain completely before these loads
      if (m == 9 || m == 17) begin
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      for (int i = 0; i < ELEMS; i++) begin
        int gap;
        if ((m >= 3 && m <= 6) || (m >= 12 && m <= 13)) gap = 0;
        else gap = $urandom_range(0, 9);
        if (m == 0) send_word(directed_left(i), directed_right(i), gap);
        else send_word(pick_value(), pick_value(), gap);
      end
    end
    in_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d words in %0d loads, %0d product elements checked (%0d clipped)",
             sb.words_taken, sb.loads_done, sb.elems_checked, sb.clipped_elems);
    $display("random input and output stalls, one long sink stall, two full drains");
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* matrix4_multiply.f */
src/m4mul_pkg.sv
src/m4mul_in_if.sv
src/m4mul_out_if.sv
src/m4mul_ram.sv
src/m4mul_seq.sv
src/m4mul_mac.sv
src/matrix4_multiply.sv
tb/sv/matrix4_multiply_tb.sv
